### rtl/alag_pkg.sv
// Shared types and codes of the alarm aggregator.
`default_nettype none

package alag_pkg;

    localparam int IDX_W   = 4;
    localparam int LEVEL_W = 2;
    localparam int MTO_W   = 16;
    // wide enough for LOWEST_LEVEL + 1 for any LOWEST_LEVEL up to 14
    localparam int TOP_W   = 4;

    localparam logic [2:0] OP_REGISTER  = 3'd0;
    localparam logic [2:0] OP_SET       = 3'd1;
    localparam logic [2:0] OP_SUPPRESS  = 3'd2;
    localparam logic [2:0] OP_GET       = 3'd3;
    localparam logic [2:0] OP_CHECK_ALL = 3'd4;
    localparam logic [2:0] OP_TICK      = 3'd5;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [IDX_W-1:0]   alarm_index;
        logic [LEVEL_W-1:0] level;
        logic               holds_watchdog;
        logic [MTO_W-1:0]   mute_timeout;
    } cmd_t;

    typedef struct packed {
        logic               alarm_is_set;
        logic               any_active;
        logic [LEVEL_W-1:0] top_level;
        logic               watchdog_hold;
    } result_t;

endpackage

`default_nettype wire

### rtl/alarm_aggregator_with_suppression_top.sv
// Top level of the alarm aggregator: command sequencer around the alarm entry memory.
//
// One command is taken when start is high and busy is low; its result is shown
// on result for exactly one cycle with done high, and must be captured then, as
// there is no way to hold it off. Register, set, suppress, get, tick and the
// unused opcodes do one read of the entry memory, then the update. check_all
// walks the entry memory one alarm per cycle through its single read port.
// A new command may be given in the cycle that done is high. No memory
// clearing pass is needed after reset.
`default_nettype none

module alarm_aggregator_with_suppression_top
    import alag_pkg::*;
#(
    parameter int NUM_ALARMS    = 16,
    parameter int LOWEST_LEVEL  = 2,
    parameter int TIMEOUT_WIDTH = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire cmd_t    cmd,
    output logic         done,
    output result_t      result
);

    localparam int IW     = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int TW     = TIMEOUT_WIDTH;
    localparam int MS_W   = 32;
    localparam int TMO_LO = MS_W;
    localparam int HOLD_B = TMO_LO + TW;
    localparam int LVL_LO = HOLD_B + 1;
    localparam int ENT_W  = LVL_LO + LEVEL_W;
    localparam logic [IW-1:0]    LAST_IDX = IW'(NUM_ALARMS - 1);
    localparam logic [TOP_W-1:0] TOP_NONE = TOP_W'(LOWEST_LEVEL + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [IW-1:0]         scan_reg, scan_next;
    logic [31:0]           now_reg, now_next;
    logic [NUM_ALARMS-1:0] registered_reg, registered_next;
    logic [NUM_ALARMS-1:0] active_reg, active_next;
    logic [NUM_ALARMS-1:0] muted_reg, muted_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;
    cmd_t                  cmd_reg, cmd_next;
    logic                  any_reg, any_next;
    logic                  wd_reg, wd_next;
    logic [TOP_W-1:0]      top_reg, top_next;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic [31:0]   in_idx32, cmd_idx32, tmo32, elapsed;
    logic [IW-1:0] in_addr, cmd_addr;
    logic          cmd_ok, running, last_scan;
    logic [TOP_W-1:0] ent_level;

    alag_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_ALARMS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_idx32  = 32'(cmd.alarm_index);
    assign cmd_idx32 = 32'(cmd_reg.alarm_index);
    assign in_addr   = in_idx32[IW-1:0];
    assign cmd_addr  = cmd_idx32[IW-1:0];
    assign cmd_ok    = cmd_idx32 < 32'(NUM_ALARMS);
    assign tmo32     = 32'(cmd_reg.mute_timeout);
    assign last_scan = (scan_reg == LAST_IDX);

    // suppression still running for the entry on the read port
    assign elapsed   = now_reg - ram_rdata[MS_W-1:0];
    assign running   = elapsed < 32'(ram_rdata[TMO_LO +: TW]);
    assign ent_level = TOP_W'(ram_rdata[LVL_LO +: LEVEL_W]);

    // Commands run strictly one after another and every write lands before
    // the next command's read is issued, so no forwarding is needed.
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        now_next        = now_reg;
        registered_next = registered_reg;
        active_next     = active_reg;
        muted_next      = muted_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        cmd_next        = cmd_reg;
        any_next        = any_reg;
        wd_next         = wd_reg;
        top_next        = top_reg;
        ram_we          = 1'b0;
        ram_waddr       = cmd_addr;
        ram_wdata       = ram_rdata;
        ram_raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.opcode != OP_CHECK_ALL)
                begin
                    ram_raddr = in_addr;
                end
                if (start)
                begin
                    cmd_next  = cmd;
                    scan_next = '0;
                    any_next  = 1'b0;
                    wd_next   = 1'b0;
                    top_next  = TOP_NONE;
                    state_next = (cmd.opcode == OP_CHECK_ALL) ? ST_SCAN : ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                result_next = '0;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
                case (cmd_reg.opcode)
                    OP_REGISTER:
                    begin
                        if (cmd_ok)
                        begin
                            registered_next[cmd_addr] = 1'b1;
                            active_next[cmd_addr]     = 1'b0;
                            muted_next[cmd_addr]      = 1'b0;
                            ram_we    = 1'b1;
                            ram_wdata = {cmd_reg.level, cmd_reg.holds_watchdog,
                                         tmo32[TW-1:0], 32'd0};
                        end
                    end
                    OP_SET:
                    begin
                        if (cmd_ok && registered_reg[cmd_addr]
                            && !(muted_reg[cmd_addr] && running))
                        begin
                            muted_next[cmd_addr]  = 1'b0;
                            active_next[cmd_addr] = 1'b1;
                        end
                    end
                    OP_SUPPRESS:
                    begin
                        if (cmd_ok && registered_reg[cmd_addr])
                        begin
                            muted_next[cmd_addr]  = 1'b1;
                            active_next[cmd_addr] = 1'b0;
                            ram_we    = 1'b1;
                            ram_wdata = {ram_rdata[ENT_W-1:MS_W], now_reg};
                        end
                    end
                    OP_GET:
                    begin
                        result_next.alarm_is_set = cmd_ok && registered_reg[cmd_addr]
                                                   && active_reg[cmd_addr];
                    end
                    OP_TICK:
                    begin
                        now_next = now_reg + 32'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_SCAN:
            begin
                ram_raddr = last_scan ? '0 : scan_reg + IW'(1);
                if (registered_reg[scan_reg])
                begin
                    // expired suppressions are released as the scan passes
                    if (muted_reg[scan_reg] && !running)
                    begin
                        muted_next[scan_reg] = 1'b0;
                    end
                    if (active_reg[scan_reg])
                    begin
                        any_next = 1'b1;
                        wd_next  = wd_reg | ram_rdata[HOLD_B];
                        if (ent_level < top_reg)
                        begin
                            top_next = ent_level;
                        end
                    end
                end
                if (last_scan)
                begin
                    result_next               = '0;
                    result_next.any_active    = any_next;
                    result_next.top_level     = top_next[LEVEL_W-1:0];
                    result_next.watchdog_hold = wd_next;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_reg       <= '0;
            now_reg        <= '0;
            registered_reg <= '0;
            active_reg     <= '0;
            muted_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            now_reg        <= now_next;
            registered_reg <= registered_next;
            active_reg     <= active_next;
            muted_reg      <= muted_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        cmd_reg    <= cmd_next;
        any_reg    <= any_next;
        wd_reg     <= wd_next;
        top_reg    <= top_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/alag_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module alag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### tb/alarm_aggregator_with_suppression_top_tb.sv
// Self-checking testbench for the alarm aggregator: directed and random commands against a predictor.
`default_nettype none

module alarm_aggregator_with_suppression_top_tb;
    import alag_pkg::*;

    localparam int N_ALARMS     = 16;
    localparam int LOWEST_LVL   = 2;
    localparam int TMO_BITS     = 16;
    localparam int RANDOM_ITEMS = 1125;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    class alarm_table_sb;
        logic [31:0]        now_ticks;
        logic               registered [N_ALARMS];
        logic               active [N_ALARMS];
        logic               muted [N_ALARMS];
        logic [LEVEL_W-1:0] lvl_of [N_ALARMS];
        logic               hold_of [N_ALARMS];
        logic [MTO_W-1:0]   mute_len [N_ALARMS];
        logic [31:0]        mute_from [N_ALARMS];
        result_t            outcome_q [$];
        int                 errors;
        int                 checked;
        int                 op_count [8];

        function new();
            int i;
            now_ticks = '0;
            for (i = 0; i < N_ALARMS; i++)
            begin
                registered[i] = 1'b0;
                active[i]     = 1'b0;
                muted[i]      = 1'b0;
                lvl_of[i]     = '0;
                hold_of[i]    = 1'b0;
                mute_len[i]   = '0;
                mute_from[i]  = '0;
            end
            for (i = 0; i < 8; i++)
                op_count[i] = 0;
            errors  = 0;
            checked = 0;
        endfunction

        // wrap-around elapsed count, as the hardware keeps it
        function bit mute_running(int i);
            logic [31:0] elapsed;
            elapsed = now_ticks - mute_from[i];
            return elapsed < {{(32 - MTO_W){1'b0}}, mute_len[i]};
        endfunction

        function result_t predict_outcome(cmd_t c);
            result_t r;
            int      idx;
            int      top;
            int      i;
            r   = '0;
            idx = c.alarm_index;
            case (c.opcode)
                OP_REGISTER:
                begin
                    if (idx < N_ALARMS)
                    begin
                        registered[idx] = 1'b1;
                        active[idx]     = 1'b0;
                        muted[idx]      = 1'b0;
                        lvl_of[idx]     = c.level;
                        hold_of[idx]    = c.holds_watchdog;
                        mute_len[idx]   = c.mute_timeout;
                        mute_from[idx]  = '0;
                    end
                end
                OP_SET:
                begin
                    if (idx < N_ALARMS && registered[idx]
                        && !(muted[idx] && mute_running(idx)))
                    begin
                        muted[idx]  = 1'b0;
                        active[idx] = 1'b1;
                    end
                end
                OP_SUPPRESS:
                begin
                    if (idx < N_ALARMS && registered[idx])
                    begin
                        muted[idx]     = 1'b1;
                        active[idx]    = 1'b0;
                        mute_from[idx] = now_ticks;
                    end
                end
                OP_GET:
                    r.alarm_is_set = idx < N_ALARMS && registered[idx] && active[idx];
                OP_CHECK_ALL:
                begin
                    top = LOWEST_LVL + 1;
                    for (i = 0; i < N_ALARMS; i++)
                    begin
                        if (registered[i])
                        begin
                            if (muted[i] && !mute_running(i))
                                muted[i] = 1'b0;
                            if (active[i])
                            begin
                                r.any_active = 1'b1;
                                if (hold_of[i])
                                    r.watchdog_hold = 1'b1;
                                if (lvl_of[i] < top)
                                    top = lvl_of[i];
                            end
                        end
                    end
                    r.top_level = LEVEL_W'(top);
                end
                OP_TICK:
                    now_ticks = now_ticks + 32'd1;
                default:
                    ;
            endcase
            return r;
        endfunction

        function void note_command(cmd_t c);
            op_count[c.opcode]++;
            outcome_q.push_back(predict_outcome(c));
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (outcome_q.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = outcome_q.pop_front();
            checked++;
            if (got.alarm_is_set !== want.alarm_is_set)
                report($sformatf("result %0d alarm_is_set %b, want %b",
                                 checked, got.alarm_is_set, want.alarm_is_set));
            if (got.any_active !== want.any_active)
                report($sformatf("result %0d any_active %b, want %b",
                                 checked, got.any_active, want.any_active));
            if (got.top_level !== want.top_level)
                report($sformatf("result %0d top_level %0d, want %0d",
                                 checked, got.top_level, want.top_level));
            if (got.watchdog_hold !== want.watchdog_hold)
                report($sformatf("result %0d watchdog_hold %b, want %b",
                                 checked, got.watchdog_hold, want.watchdog_hold));
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    alarm_table_sb sb = new();
    int            cycle_count;
    int            sent;
    bit            quiet;

    alarm_aggregator_with_suppression_top #(
        .NUM_ALARMS    (N_ALARMS),
        .LOWEST_LEVEL  (LOWEST_LVL),
        .TIMEOUT_WIDTH (TMO_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    function automatic cmd_t mk(logic [2:0] op, int idx, int lvl = 0, bit hold = 0,
                                int tmo = 0);
        cmd_t c;
        c.opcode         = op;
        c.alarm_index    = IDX_W'(idx);
        c.level          = LEVEL_W'(lvl);
        c.holds_watchdog = hold;
        c.mute_timeout   = MTO_W'(tmo);
        return c;
    endfunction

    function automatic int next_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // mostly short timeouts so that suppressions run out within the run
    function automatic int rand_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 6);
        else if (r < 85)
            return $urandom_range(7, 40);
        return $urandom_range(0, 65535);
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   r;
        r = $urandom_range(0, 99);
        c.alarm_index    = IDX_W'($urandom_range(0, N_ALARMS - 1));
        c.level          = LEVEL_W'($urandom_range(0, 3));
        c.holds_watchdog = 1'($urandom_range(0, 1));
        c.mute_timeout   = MTO_W'(rand_timeout());
        if (r < 10)
            c.opcode = OP_REGISTER;
        else if (r < 35)
            c.opcode = OP_SET;
        else if (r < 47)
            c.opcode = OP_SUPPRESS;
        else if (r < 59)
            c.opcode = OP_GET;
        else if (r < 74)
            c.opcode = OP_CHECK_ALL;
        else if (r < 96)
            c.opcode = OP_TICK;
        else if (r < 98)
            c.opcode = OP_SPARE6;
        else
            c.opcode = OP_SPARE7;
        return c;
    endfunction

    // transfer one command; start stays high until it is taken
    task automatic issue(cmd_t c);
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    task automatic send(cmd_t c);
        issue(c);
        pause(next_gap());
        sent++;
        if (sent % 50 == 0)
            quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic drain();
        pause(1);
        while (sb.outcome_q.size() != 0)
            @(posedge clk);
    endtask

    // sometimes register and set first; suppress, then ticks, set tries and scans; then set and get
    task automatic mute_sequence();
        int idx;
        int steps;
        int k;
        int r;
        idx = $urandom_range(0, N_ALARMS - 1);
        if ($urandom_range(0, 99) < 40)
        begin
            send(mk(OP_REGISTER, idx, $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 8)));
            send(mk(OP_SET, idx));
        end
        send(mk(OP_SUPPRESS, idx));
        steps = $urandom_range(0, 8);
        for (k = 0; k < steps; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                send(mk(OP_TICK, $urandom_range(0, 15)));
            else if (r < 8)
                send(mk(OP_SET, idx));
            else
                send(mk(OP_CHECK_ALL, $urandom_range(0, 15)));
        end
        send(mk(OP_SET, idx));
        send(mk(OP_GET, idx));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        sent  = 0;
        quiet = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unregistered entries and an empty table
        send(mk(OP_GET, 0));
        send(mk(OP_SET, 3));
        send(mk(OP_SUPPRESS, 3));
        send(mk(OP_CHECK_ALL, 0));
        send(mk(OP_REGISTER, 0, 0, 1, 16'hFFFF));
        // level above the lowest, and a suppression that ends at once
        send(mk(OP_REGISTER, 15, 3, 0, 0));
        send(mk(OP_REGISTER, 7, 2, 0, 2));
        send(mk(OP_SET, 15));
        send(mk(OP_CHECK_ALL, 0));
        send(mk(OP_SET, 7));
        send(mk(OP_CHECK_ALL, 0));
        // set is refused until elapsed ticks reach the timeout
        send(mk(OP_SUPPRESS, 7));
        send(mk(OP_SET, 7));
        send(mk(OP_TICK, 0));
        send(mk(OP_SET, 7));
        send(mk(OP_TICK, 0));
        send(mk(OP_SET, 7));
        send(mk(OP_GET, 7));
        send(mk(OP_SUPPRESS, 15));
        send(mk(OP_SET, 15));
        send(mk(OP_SET, 0));
        send(mk(OP_CHECK_ALL, 0));
        send(mk(OP_SUPPRESS, 0));
        send(mk(OP_SET, 0));
        // re-registering clears the entry
        send(mk(OP_REGISTER, 7, 1, 1, 5));
        send(mk(OP_GET, 7));
        send(mk(OP_SPARE6, 15, 3, 1, 16'hFFFF));
        send(mk(OP_SPARE7, 15, 3, 1, 16'hFFFF));
        send(mk(OP_CHECK_ALL, 15, 3, 1, 16'hFFFF));
        drain();

        while (sent < RANDOM_ITEMS + 29)
        begin
            if ($urandom_range(0, 99) < 25)
                mute_sequence();
            else
                send(rand_cmd());
            if ($urandom_range(0, 199) == 0)
                drain();
        end

        drain();
        repeat (2 * (N_ALARMS + 1) + 4)
            @(posedge clk);
        if (sb.outcome_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outcome_q.size()));

        $display("sent %0d commands: %0d register, %0d set, %0d suppress, %0d get, %0d check_all",
                 sent, sb.op_count[OP_REGISTER], sb.op_count[OP_SET],
                 sb.op_count[OP_SUPPRESS], sb.op_count[OP_GET], sb.op_count[OP_CHECK_ALL]);
        $display("%0d tick, %0d unused opcodes; %0d results compared, %0d mismatches",
                 sb.op_count[OP_TICK], sb.op_count[OP_SPARE6] + sb.op_count[OP_SPARE7],
                 sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/alag_pkg.sv
rtl/alag_ram.sv
rtl/alarm_aggregator_with_suppression_top.sv
tb/alarm_aggregator_with_suppression_top_tb.sv
